// ===== sv/qpsg_pkg.sv =====
// Shared constants, types and the arctangent table of the quadratic-phase sequence generator.
package qpsg_pkg;

    localparam int MAX_LENGTH    = 4096;
    localparam int LEN_W         = 13;
    localparam int IDX_W         = 12;
    localparam int COEF_W        = 12;
    localparam int TURN_W        = 24;
    localparam int AMP_W         = 15;
    localparam int OUT_W         = 16;
    localparam int CFG_W         = 24;
    localparam int ADDR_W        = 3;
    localparam int PROD_W        = 2 * (IDX_W + 1);
    localparam int TRI_W         = 24;
    localparam int LIN_W         = IDX_W + COEF_W;
    localparam int QUAD_W        = TRI_W + COEF_W;
    localparam int SUM_W         = QUAD_W + 1;
    localparam int MOD_STEPS     = SUM_W;
    localparam int SHIFT_W       = SUM_W + LEN_W;
    localparam int ATAN_ENTRIES  = 24;
    localparam int CORDIC_STAGES = 16;
    localparam int NUM_ROT       = (CORDIC_STAGES < ATAN_ENTRIES) ? CORDIC_STAGES : ATAN_ENTRIES;
    localparam int DP_W          = 34;
    localparam int ANGLE_W       = 32;
    localparam logic [31:0] GAIN_Q32 = 32'h9B74EDA8;

    typedef enum logic [ADDR_W-1:0] {
        REG_SEQ_LENGTH    = 3'd0,
        REG_LINEAR_COEF   = 3'd1,
        REG_QUAD_COEF     = 3'd2,
        REG_TURN_PER_UNIT = 3'd3,
        REG_AMPLITUDE     = 3'd4
    } cfg_reg_t;

    typedef struct packed {
        logic             valid;
        logic [IDX_W-1:0] idx;
        logic [IDX_W-1:0] phase;
    } phase_item_t;

    // Arctangent of 2^-k in units of 2^-32 turn.
    function automatic logic [ANGLE_W-1:0] atan_turn(input int unsigned k);
        logic [ANGLE_W-1:0] a;
        case (k)
            0:  a = 32'h20000000;
            1:  a = 32'h12E4051E;
            2:  a = 32'h09FB385B;
            3:  a = 32'h051111D4;
            4:  a = 32'h028B0D43;
            5:  a = 32'h0145D7E1;
            6:  a = 32'h00A2F61E;
            7:  a = 32'h00517C55;
            8:  a = 32'h0028BE53;
            9:  a = 32'h00145F2F;
            10: a = 32'h000A2F98;
            11: a = 32'h000517CC;
            12: a = 32'h00028BE6;
            13: a = 32'h000145F3;
            14: a = 32'h0000A2FA;
            15: a = 32'h0000517D;
            16: a = 32'h000028BE;
            17: a = 32'h0000145F;
            18: a = 32'h00000A30;
            19: a = 32'h00000518;
            20: a = 32'h0000028C;
            21: a = 32'h00000146;
            22: a = 32'h000000A3;
            23: a = 32'h00000051;
            default: a = '0;
        endcase
        return a;
    endfunction

endpackage

// ===== sv/qpsg_phase.sv =====
// Phase pipeline: polynomial products, then a restoring modulo, one quotient bit per stage.
module qpsg_phase (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        en,
    input  logic                        in_valid,
    input  logic [qpsg_pkg::IDX_W-1:0]  in_index,
    input  logic [qpsg_pkg::LEN_W-1:0]  len_eff,
    input  logic [qpsg_pkg::COEF_W-1:0] lin_coef,
    input  logic [qpsg_pkg::COEF_W-1:0] quad_coef,
    output qpsg_pkg::phase_item_t       out_item
);
    import qpsg_pkg::*;

    logic              s1_valid_reg;
    logic [IDX_W-1:0]  s1_idx_reg;
    logic [PROD_W-1:0] s1_prod_reg;
    logic [LIN_W-1:0]  s1_lin_reg;
    logic              s2_valid_reg;
    logic [IDX_W-1:0]  s2_idx_reg;
    logic [QUAD_W-1:0] s2_quad_reg;
    logic [LIN_W-1:0]  s2_lin_reg;
    logic [IDX_W:0]    ip1;
    logic [IDX_W:0]    ip2;
    logic [TRI_W-1:0]  tri_num;

    logic              m_valid_reg [0:MOD_STEPS];
    logic [IDX_W-1:0]  m_idx_reg   [0:MOD_STEPS];
    logic [SUM_W-1:0]  m_rem_reg   [0:MOD_STEPS];

    assign ip1     = {1'b0, in_index} + (IDX_W+1)'(1);
    assign ip2     = {1'b0, in_index} + (IDX_W+1)'(2);
    assign tri_num = s1_prod_reg[TRI_W:1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg   <= 1'b0;
            s2_valid_reg   <= 1'b0;
            m_valid_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            s1_valid_reg   <= in_valid;
            s2_valid_reg   <= s1_valid_reg;
            m_valid_reg[0] <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_idx_reg   <= in_index;
            s1_prod_reg  <= ip1 * ip2;
            s1_lin_reg   <= in_index * lin_coef;
            s2_idx_reg   <= s1_idx_reg;
            s2_quad_reg  <= tri_num * quad_coef;
            s2_lin_reg   <= s1_lin_reg;
            m_idx_reg[0] <= s2_idx_reg;
            m_rem_reg[0] <= SUM_W'(s2_lin_reg) + SUM_W'(s2_quad_reg);
        end
    end

    genvar j;
    generate
        for (j = 0; j < MOD_STEPS; j++)
        begin : g_mod
            localparam int POS = MOD_STEPS - 1 - j;
            logic [SHIFT_W-1:0] n_sh;
            logic [SHIFT_W-1:0] r_ext;
            logic               ge;

            assign n_sh  = SHIFT_W'(len_eff) << POS;
            assign r_ext = SHIFT_W'(m_rem_reg[j]);
            assign ge    = (r_ext >= n_sh);

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    m_valid_reg[j+1] <= 1'b0;
                end
                else if (en)
                begin
                    m_valid_reg[j+1] <= m_valid_reg[j];
                end
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    m_idx_reg[j+1] <= m_idx_reg[j];
                    m_rem_reg[j+1] <= ge ? (m_rem_reg[j] - n_sh[SUM_W-1:0]) : m_rem_reg[j];
                end
            end
        end
    endgenerate

    // A zero length applies no modulus and yields phase zero.
    assign out_item.valid = m_valid_reg[MOD_STEPS];
    assign out_item.idx   = m_idx_reg[MOD_STEPS];
    assign out_item.phase = (len_eff == '0) ? '0 : m_rem_reg[MOD_STEPS][IDX_W-1:0];

endmodule

// ===== sv/qpsg_cordic.sv =====
// Turn conversion, pipelined CORDIC rotation and Q1.15 rounding of one sample per cycle while en is high.
module qpsg_cordic (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              en,
    input  qpsg_pkg::phase_item_t             in_item,
    input  logic [qpsg_pkg::TURN_W-1:0]       turn_per_unit,
    input  logic [qpsg_pkg::AMP_W-1:0]        amplitude,
    output logic                              out_valid,
    output logic [qpsg_pkg::IDX_W-1:0]        out_index,
    output logic signed [qpsg_pkg::OUT_W-1:0] real_part,
    output logic signed [qpsg_pkg::OUT_W-1:0] imag_part
);
    import qpsg_pkg::*;

    logic                    s0_valid_reg;
    logic [IDX_W-1:0]        s0_idx_reg;
    logic [TURN_W-1:0]       s0_turn_reg;
    logic signed [DP_W-1:0]  s0_x_reg;
    logic [IDX_W+TURN_W-1:0] turn_prod;
    logic [AMP_W+31:0]       gain_prod;
    logic [ANGLE_W-1:0]      theta;
    logic                    s0_neg;
    logic [ANGLE_W-1:0]      theta_f;

    logic                    r_valid_reg [1:NUM_ROT];
    logic [IDX_W-1:0]        r_idx_reg   [1:NUM_ROT];
    logic                    r_neg_reg   [1:NUM_ROT];
    logic signed [DP_W-1:0]  r_x_reg     [1:NUM_ROT];
    logic signed [DP_W-1:0]  r_y_reg     [1:NUM_ROT];
    logic signed [DP_W-1:0]  r_z_reg     [1:NUM_ROT];

    logic                    o_valid_reg;
    logic [IDX_W-1:0]        o_idx_reg;
    logic signed [OUT_W-1:0] o_re_reg;
    logic signed [OUT_W-1:0] o_im_reg;

    assign turn_prod = in_item.phase * turn_per_unit;
    assign gain_prod = amplitude * GAIN_Q32;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s0_valid_reg <= in_item.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s0_idx_reg  <= in_item.idx;
            s0_turn_reg <= turn_prod[TURN_W-1:0];
            s0_x_reg    <= DP_W'(gain_prod[AMP_W+31:16]);
        end
    end

    // Fold the angle into a quarter turn either way; the half-turn fold negates the result.
    assign theta   = {s0_turn_reg, 8'd0};
    assign s0_neg  = theta[ANGLE_W-1] ^ theta[ANGLE_W-2];
    assign theta_f = {theta[ANGLE_W-1] ^ s0_neg, theta[ANGLE_W-2:0]};

    genvar k;
    generate
        for (k = 0; k < NUM_ROT; k++)
        begin : g_rot
            logic                   vi;
            logic [IDX_W-1:0]       ii;
            logic                   ni;
            logic signed [DP_W-1:0] xi;
            logic signed [DP_W-1:0] yi;
            logic signed [DP_W-1:0] zi;
            logic signed [DP_W-1:0] dx;
            logic signed [DP_W-1:0] dy;
            logic signed [DP_W-1:0] at;

            if (k == 0)
            begin : g_first
                assign vi = s0_valid_reg;
                assign ii = s0_idx_reg;
                assign ni = s0_neg;
                assign xi = s0_x_reg;
                assign yi = '0;
                assign zi = DP_W'($signed(theta_f));
            end
            else
            begin : g_next
                assign vi = r_valid_reg[k];
                assign ii = r_idx_reg[k];
                assign ni = r_neg_reg[k];
                assign xi = r_x_reg[k];
                assign yi = r_y_reg[k];
                assign zi = r_z_reg[k];
            end

            assign dx = yi >>> k;
            assign dy = xi >>> k;
            assign at = DP_W'(atan_turn(k));

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    r_valid_reg[k+1] <= 1'b0;
                end
                else if (en)
                begin
                    r_valid_reg[k+1] <= vi;
                end
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    r_idx_reg[k+1] <= ii;
                    r_neg_reg[k+1] <= ni;
                    if (!zi[DP_W-1])
                    begin
                        r_x_reg[k+1] <= xi - dx;
                        r_y_reg[k+1] <= yi + dy;
                        r_z_reg[k+1] <= zi - at;
                    end
                    else
                    begin
                        r_x_reg[k+1] <= xi + dx;
                        r_y_reg[k+1] <= yi - dy;
                        r_z_reg[k+1] <= zi + at;
                    end
                end
            end
        end
    endgenerate

    function automatic logic signed [OUT_W-1:0] to_q15(input logic signed [DP_W-1:0] v);
        logic signed [DP_W:0]    s;
        logic signed [DP_W-16:0] q;
        logic signed [OUT_W-1:0] r;
        s = (DP_W+1)'(v) + (DP_W+1)'(32768);
        q = (DP_W-15)'(s >>> 16);
        if (q > (DP_W-15)'(32767))
            r = 16'sd32767;
        else if (q < -(DP_W-15)'(32768))
            r = -16'sd32768;
        else
            r = q[OUT_W-1:0];
        return r;
    endfunction

    logic signed [DP_W-1:0] fx;
    logic signed [DP_W-1:0] fy;
    assign fx = r_neg_reg[NUM_ROT] ? -r_x_reg[NUM_ROT] : r_x_reg[NUM_ROT];
    assign fy = r_neg_reg[NUM_ROT] ? -r_y_reg[NUM_ROT] : r_y_reg[NUM_ROT];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            o_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            o_valid_reg <= r_valid_reg[NUM_ROT];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            o_idx_reg <= r_idx_reg[NUM_ROT];
            o_re_reg  <= to_q15(fx);
            o_im_reg  <= to_q15(fy);
        end
    end

    assign out_valid = o_valid_reg;
    assign out_index = o_idx_reg;
    assign real_part = o_re_reg;
    assign imag_part = o_im_reg;

endmodule

// ===== sv/quadratic_phase_sequence_gen.sv =====
// Top level of the quadratic-phase sequence generator: registers, pipeline and flow control.
// For each requested element index i this block returns amplitude*exp(j*2*pi*t) in signed
// Q1.15, where the phase p = (i*r + b*(i+1)(i+2)/2) mod n is turned into a 24-bit turn
// fraction t = p*turn_per_unit and rotated by a 16-stage CORDIC. The block takes one request
// per clock and delivers one result per clock while the output does not stall; it holds 3 product
// and sum stages, the 37 restoring modulo stages of the phase pipeline, 1 turn conversion stage,
// the 16 CORDIC rotation stages and 1 output rounding stage. The whole pipeline
// advances whenever the output register is empty or being taken, so a stall at the output
// holds every stage in place. Registers are written through cfg_we/cfg_addr/cfg_wdata and
// must only be changed while no request is in flight; a length above 4096 acts as 4096 and a
// length of zero forces phase zero.
module quadratic_phase_sequence_gen (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [qpsg_pkg::ADDR_W-1:0]        cfg_addr,
    input  logic [qpsg_pkg::CFG_W-1:0]         cfg_wdata,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [qpsg_pkg::IDX_W-1:0]         elem_index,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [qpsg_pkg::IDX_W-1:0]         out_index,
    output logic signed [qpsg_pkg::OUT_W-1:0]  real_part,
    output logic signed [qpsg_pkg::OUT_W-1:0]  imag_part
);
    import qpsg_pkg::*;

    logic [LEN_W-1:0]  seq_length_reg;
    logic [COEF_W-1:0] linear_coef_reg;
    logic [COEF_W-1:0] quad_coef_reg;
    logic [TURN_W-1:0] turn_per_unit_reg;
    logic [AMP_W-1:0]  amplitude_reg;
    logic [LEN_W-1:0]  len_eff;
    logic              advance;
    phase_item_t       phase_item;

    // Register writes; an index outside the list is dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_length_reg    <= LEN_W'(2);
            linear_coef_reg   <= '0;
            quad_coef_reg     <= '0;
            turn_per_unit_reg <= '0;
            amplitude_reg     <= AMP_W'(32767);
        end
        else if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_addr))
                REG_SEQ_LENGTH:    seq_length_reg    <= cfg_wdata[LEN_W-1:0];
                REG_LINEAR_COEF:   linear_coef_reg   <= cfg_wdata[COEF_W-1:0];
                REG_QUAD_COEF:     quad_coef_reg     <= cfg_wdata[COEF_W-1:0];
                REG_TURN_PER_UNIT: turn_per_unit_reg <= cfg_wdata[TURN_W-1:0];
                REG_AMPLITUDE:     amplitude_reg     <= cfg_wdata[AMP_W-1:0];
                default:           ;
            endcase
        end
    end

    // Lengths beyond the supported maximum behave as the maximum.
    assign len_eff = (seq_length_reg > LEN_W'(MAX_LENGTH)) ? LEN_W'(MAX_LENGTH)
                                                            : seq_length_reg;

    // The pipeline moves as one whenever the output register can take a new result.
    assign advance  = !out_valid || out_ready;
    assign in_ready = advance;

    qpsg_phase u_phase (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (advance),
        .in_valid  (in_valid),
        .in_index  (elem_index),
        .len_eff   (len_eff),
        .lin_coef  (linear_coef_reg),
        .quad_coef (quad_coef_reg),
        .out_item  (phase_item)
    );

    qpsg_cordic u_cordic (
        .clk           (clk),
        .rst_n         (rst_n),
        .en            (advance),
        .in_item       (phase_item),
        .turn_per_unit (turn_per_unit_reg),
        .amplitude     (amplitude_reg),
        .out_valid     (out_valid),
        .out_index     (out_index),
        .real_part     (real_part),
        .imag_part     (imag_part)
    );

`ifndef ASSERT_OFF
    // Requests are refused only while a finished result waits at the output.
    a_ready_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (out_valid && !out_ready))
        else $error("request refused with free output register");

    // A result that was not taken is still offered in the next cycle.
    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> out_valid)
        else $error("pending result dropped");

    // The reduced phase lies below the effective length whenever that length is nonzero.
    a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_item.valid && (len_eff != '0)) |-> ({1'b0, phase_item.phase} < len_eff))
        else $error("phase not reduced below length");
`endif

endmodule

// ===== tb/sv/quadratic_phase_sequence_gen_tb.sv =====
// Self-checking testbench for the quadratic-phase sequence generator.
`timescale 1ns / 1ps

module quadratic_phase_sequence_gen_tb;
    import qpsg_pkg::*;

    // Expected element, as the block should deliver it.
    typedef struct {
        logic [IDX_W-1:0]        idx;
        logic signed [OUT_W-1:0] re;
        logic signed [OUT_W-1:0] im;
    } element_t;

    // Predicts each element from its own copy of the registers and keeps the
    // expected elements in request order.
    class phase_scoreboard;
        logic [LEN_W-1:0]  len_r;
        logic [COEF_W-1:0] lin_r;
        logic [COEF_W-1:0] quad_r;
        logic [TURN_W-1:0] turn_r;
        logic [AMP_W-1:0]  amp_r;
        element_t          pending[$];
        int                errors;

        function void reset_regs();
            len_r = 2; lin_r = 0; quad_r = 0; turn_r = 0; amp_r = 15'h7FFF;
            errors = 0;
        endfunction

        function void write_reg(logic [ADDR_W-1:0] a, logic [CFG_W-1:0] d);
            case (a)
                REG_SEQ_LENGTH:    len_r  = d[LEN_W-1:0];
                REG_LINEAR_COEF:   lin_r  = d[COEF_W-1:0];
                REG_QUAD_COEF:     quad_r = d[COEF_W-1:0];
                REG_TURN_PER_UNIT: turn_r = d[TURN_W-1:0];
                REG_AMPLITUDE:     amp_r  = d[AMP_W-1:0];
                default: ;
            endcase
        endfunction

        function logic signed [OUT_W-1:0] round_q15(longint v);
            longint q;
            q = (v + 32768) >>> 16;
            if (q > 32767) q = 32767;
            if (q < -32768) q = -32768;
            return q[OUT_W-1:0];
        endfunction

        function void note_request(logic [IDX_W-1:0] idx);
            longint unsigned n, i, ph;
            logic [31:0] theta;
            logic        flip;
            longint      x, y, z, dx, dy;
            element_t    e;
            i = idx;
            n = len_r;
            ph = 0;
            if (n > MAX_LENGTH) n = MAX_LENGTH;
            // A zero length applies no modulus and leaves the phase at zero.
            if (n != 0)
                ph = ((i % n) * (lin_r % n) + ((((i + 1) * (i + 2)) / 2) % n) * (quad_r % n))
                     % n;
            theta = {32'(((ph * turn_r) & 64'hFFFFFF)) << 8};
            flip = theta[31] ^ theta[30];
            if (flip) theta = theta - 32'h80000000;
            z = longint'($signed(theta));
            x = longint'((64'(amp_r) * 64'(GAIN_Q32)) >> 16);
            y = 0;
            for (int k = 0; k < NUM_ROT; k++) begin
                dx = y >>> k;
                dy = x >>> k;
                if (z >= 0) begin
                    x -= dx; y += dy; z -= longint'(atan_turn(k));
                end
                else begin
                    x += dx; y -= dy; z += longint'(atan_turn(k));
                end
            end
            if (flip) begin
                x = -x; y = -y;
            end
            e.idx = idx;
            e.re = round_q15(x);
            e.im = round_q15(y);
            pending.push_back(e);
        endfunction

        function void check_element(logic [IDX_W-1:0] idx, logic signed [OUT_W-1:0] re,
                                    logic signed [OUT_W-1:0] im);
            element_t e;
            if (pending.size() == 0) begin
                $error("unexpected element, index %0d", idx);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (idx !== e.idx) begin
                $error("out_index: expected %0d, actual %0d", e.idx, idx); errors++;
            end
            if (re !== e.re) begin
                $error("real_part: expected %0d, actual %0d", e.re, re); errors++;
            end
            if (im !== e.im) begin
                $error("imag_part: expected %0d, actual %0d", e.im, im); errors++;
            end
        endfunction
    endclass

    logic clk, rst_n;
    logic cfg_we;
    logic [ADDR_W-1:0] cfg_addr;
    logic [CFG_W-1:0]  cfg_wdata;
    logic in_valid, in_ready, out_valid, out_ready;
    logic [IDX_W-1:0] elem_index, out_index;
    logic signed [OUT_W-1:0] real_part, imag_part;

    // The pipeline is 58 stages deep; this margin covers the drain after the last element.
    localparam int DRAIN_CYCLES = 120;

    phase_scoreboard sb = new();
    bit hold_off;     // long receiver hold-off, requested by the stimulus
    int hold_len;

    quadratic_phase_sequence_gen dut (.*);

    initial begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    // Results are sampled at the edge; the expectation is popped in the same edge.
    always @(posedge clk)
        if (rst_n && out_valid && out_ready)
            sb.check_element(out_index, real_part, imag_part);

    // Receiver: random stall pattern, plain stretches, and an occasional long hold-off.
    initial begin
        int mode;
        out_ready <= 1'b0;
        mode = 0;
        forever begin
            @(posedge clk);
            if (hold_off) begin
                out_ready <= 1'b0;
                repeat (hold_len) @(posedge clk);
                hold_off = 0;
            end
            if ($urandom_range(0, 63) == 0) mode = $urandom_range(0, 2);
            case (mode)
                0: out_ready <= 1'b1;
                1: out_ready <= ($urandom_range(0, 3) != 0);
                default: out_ready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    task automatic write_reg(cfg_reg_t a, logic [CFG_W-1:0] d);
        cfg_we <= 1'b1; cfg_addr <= a; cfg_wdata <= d;
        sb.write_reg(a, d);
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // Offers one request and holds it until the block takes it.
    task automatic send_request(logic [IDX_W-1:0] idx);
        in_valid <= 1'b1;
        elem_index <= idx;
        do @(posedge clk); while (!in_ready);
        sb.note_request(idx);
    endtask

    // Sender in bursts: random-length bursts separated by random gaps.
    int burst_left = 0;
    task automatic paced_request(logic [IDX_W-1:0] idx);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        send_request(idx);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic setup(int n, int r, int b, int tpu, int amp);
        write_reg(REG_SEQ_LENGTH, CFG_W'(n));
        write_reg(REG_LINEAR_COEF, CFG_W'(r));
        write_reg(REG_QUAD_COEF, CFG_W'(b));
        write_reg(REG_TURN_PER_UNIT, CFG_W'(tpu));
        write_reg(REG_AMPLITUDE, CFG_W'(amp));
    endtask

    // Length cycles between small, mid and the extremes, including zero and above bound.
    function automatic int pick_length();
        case ($urandom_range(0, 9))
            0: return 0;
            1: return $urandom_range(4097, 8191);
            2: return 4096;
            3: return 2;
            4, 5: return $urandom_range(2, 64);
            default: return $urandom_range(2, 4096);
        endcase
    endfunction

    initial begin
        int n, tpu;
        rst_n = 1'b0;
        cfg_we = 1'b0; cfg_addr = '0; cfg_wdata = '0;
        in_valid = 1'b0; elem_index = '0;
        hold_off = 0; hold_len = 0;
        sb.reset_regs();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings first, then the extremes of every register.
        send_request(0);
        send_request(12'hFFF);
        drain();
        setup(4096, 4095, 4095, 24'hFFFFFF, 32767);
        send_request(0); send_request(1); send_request(12'hFFF); send_request(12'hAAA);
        send_request(12'h555);
        drain();
        setup(7, 3, 5, 2396745, 0);
        send_request(6); send_request(7); send_request(100);
        drain();
        // Zero length forces phase zero; length above bound acts as the bound.
        setup(0, 4095, 4095, 12345, 20000);
        send_request(5); send_request(12'hFFF);
        drain();
        setup(8191, 1, 1, 4096, 512);
        send_request(4095); send_request(2048); send_request(3);
        drain();
        // A write to an unused index must change nothing.
        cfg_we <= 1'b1; cfg_addr <= 3'd7; cfg_wdata <= 24'hFFFFFF;
        @(posedge clk);
        cfg_we <= 1'b0;
        send_request(9);
        drain();

        // Random phases, each with its own register setting.
        for (int phase_no = 0; phase_no < 20; phase_no++) begin
            n = pick_length();
            tpu = (n != 0) ? (16777216 + n / 2) / ((n > 4096) ? 4096 : n) : $urandom();
            if ($urandom_range(0, 4) == 0) tpu = $urandom_range(0, 24'hFFFFFF);
            setup(n, $urandom_range(0, 4095), $urandom_range(0, 4095), tpu,
                  ($urandom_range(0, 5) == 0) ? $urandom_range(0, 32767)
                  : 32767 / ((n < 2) ? 1 : $rtoi($sqrt(real'(n))) + 1));
            if (phase_no == 3) begin
                // Long output hold-off while the sender keeps offering requests.
                hold_len = 300;
                hold_off = 1;
            end
            for (int k = 0; k < 100; k++)
                paced_request(IDX_W'(($urandom_range(0, 7) == 0) ? $urandom_range(0, 4095)
                              : ((n >= 2) ? $urandom_range(0, ((n > 4096) ? 4096 : n) - 1)
                                          : $urandom_range(0, 4095))));
            drain();
        end

        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    initial begin
        #5ms;
        $display("== FAIL ==");
        $finish;
    end
endmodule
